>>> rtl/sog_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sog_pkg;

	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'd1;

	localparam logic [CFG_W-1:0] NUM_ROWS_RST = 9'd4;
	localparam logic [CFG_W-1:0] NUM_COLS_RST = 9'd4;

	localparam int ROW_W = 8;
	localparam int COL_W = 8;
	localparam int LIN_W = 16;
	localparam int SEQ_W = 17;

	typedef enum logic [3:0] {
		DIR_RIGHT = 4'b0001,
		DIR_DOWN  = 4'b0010,
		DIR_LEFT  = 4'b0100,
		DIR_UP    = 4'b1000
	} dir_t;

endpackage

`default_nettype wire

>>> rtl/sog_step.sv
`timescale 1ns / 1ps
`default_nettype none

module sog_step #(
	parameter int CRD_W = 8,
	parameter int DIM_W = 9,
	parameter int LIN_FW = 16
) (
	input  wire logic [DIM_W-1:0]  lat_cols,
	input  wire sog_pkg::dir_t     dir,
	input  wire logic [CRD_W-1:0]  cur_row,
	input  wire logic [CRD_W-1:0]  cur_col,
	input  wire logic [CRD_W-1:0]  top_bound,
	input  wire logic [CRD_W-1:0]  bottom_bound,
	input  wire logic [CRD_W-1:0]  left_bound,
	input  wire logic [CRD_W-1:0]  right_bound,
	input  wire logic [LIN_FW-1:0] lin,
	output sog_pkg::dir_t          dir_nx,
	output logic [CRD_W-1:0]       row_nx,
	output logic [CRD_W-1:0]       col_nx,
	output logic [CRD_W-1:0]       top_nx,
	output logic [CRD_W-1:0]       bottom_nx,
	output logic [CRD_W-1:0]       left_nx,
	output logic [CRD_W-1:0]       right_nx,
	output logic [LIN_FW-1:0]      lin_nx
);

	localparam int XW = (LIN_FW > DIM_W) ? LIN_FW : DIM_W;

	logic [XW-1:0]     cols_x;
	logic [LIN_FW-1:0] stride;

	assign cols_x = XW'(lat_cols);
	assign stride = cols_x[LIN_FW-1:0];

	always_comb begin
		dir_nx    = dir;
		row_nx    = cur_row;
		col_nx    = cur_col;
		top_nx    = top_bound;
		bottom_nx = bottom_bound;
		left_nx   = left_bound;
		right_nx  = right_bound;
		lin_nx    = lin;
		case (dir)
			sog_pkg::DIR_RIGHT: begin
				if (cur_col < right_bound) begin
					col_nx = cur_col + 1'b1;
					lin_nx = lin + 1'b1;
				end else begin
					top_nx = top_bound + 1'b1;
					dir_nx = sog_pkg::DIR_DOWN;
					row_nx = cur_row + 1'b1;
					lin_nx = lin + stride;
				end
			end
			sog_pkg::DIR_DOWN: begin
				if (cur_row < bottom_bound) begin
					row_nx = cur_row + 1'b1;
					lin_nx = lin + stride;
				end else begin
					right_nx = right_bound - 1'b1;
					dir_nx   = sog_pkg::DIR_LEFT;
					col_nx   = cur_col - 1'b1;
					lin_nx   = lin - 1'b1;
				end
			end
			sog_pkg::DIR_LEFT: begin
				if (cur_col > left_bound) begin
					col_nx = cur_col - 1'b1;
					lin_nx = lin - 1'b1;
				end else begin
					bottom_nx = bottom_bound - 1'b1;
					dir_nx    = sog_pkg::DIR_UP;
					row_nx    = cur_row - 1'b1;
					lin_nx    = lin - stride;
				end
			end
			sog_pkg::DIR_UP: begin
				if (cur_row > top_bound) begin
					row_nx = cur_row - 1'b1;
					lin_nx = lin - stride;
				end else begin
					left_nx = left_bound + 1'b1;
					dir_nx  = sog_pkg::DIR_RIGHT;
					col_nx  = cur_col + 1'b1;
					lin_nx  = lin + 1'b1;
				end
			end
			default: begin
				dir_nx = dir;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/spiral_order_address_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// spiral order address generator
// input channel: in_valid / in_stall with restart; every accepted item yields
//   exactly one result item: the next cell of a clockwise spiral over the
//   num_rows by num_cols matrix, starting at the top-left corner
// output channel: out_valid / out_stall with row, col, linear_index,
//   sequence_value and last
// latency: the result is valid the cycle after its item is accepted
// throughput: one item per cycle unless in_stall is high; the walk state and the
//   running linear index update once per item through a single add/compare step
// the output register holds one result; in_stall is high only while that
//   result is held by out_stall, so a stalled receiver holds the payload
//   and back-pressures the input without losing or repeating cells
// configuration: cfg_we writes num_rows (index 0) or num_cols (index 1);
//   new dimensions are latched when the next spiral begins
// reset: dimensions return to 4 by 4, no result is pending and the first item
//   begins a new spiral

module spiral_order_address_generator #(
	parameter int MAX_DIM = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sog_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sog_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          restart,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [sog_pkg::ROW_W-1:0]          row,
	output logic [sog_pkg::COL_W-1:0]          col,
	output logic [sog_pkg::LIN_W-1:0]          linear_index,
	output logic [sog_pkg::SEQ_W-1:0]          sequence_value,
	output logic                               last
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CRD_W  = $clog2(MAX_DIM);
	localparam int LIN_FW = $clog2(MAX_DIM * MAX_DIM);
	localparam int CNT_W  = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int CMP_W  = ((sog_pkg::CFG_W > DIM_W) ? sog_pkg::CFG_W : DIM_W) + 1;
	localparam int CRD_XW = CRD_W + sog_pkg::ROW_W;
	localparam int LIN_XW = LIN_FW + sog_pkg::LIN_W;
	localparam int CNT_XW = CNT_W + sog_pkg::SEQ_W;

	logic [sog_pkg::CFG_W-1:0] num_rows_q;
	logic [sog_pkg::CFG_W-1:0] num_cols_q;

	logic [DIM_W-1:0]  lat_cols_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  cnt_q;
	sog_pkg::dir_t     dir_q;
	logic [CRD_W-1:0]  row_q;
	logic [CRD_W-1:0]  col_q;
	logic [CRD_W-1:0]  top_q;
	logic [CRD_W-1:0]  bottom_q;
	logic [CRD_W-1:0]  left_q;
	logic [CRD_W-1:0]  right_q;
	logic [LIN_FW-1:0] lin_q;
	logic              out_valid_q;
	logic              last_q;

	logic [CMP_W-1:0]  rows_x;
	logic [CMP_W-1:0]  cols_x;
	logic [DIM_W-1:0]  rows_cl;
	logic [DIM_W-1:0]  cols_cl;
	logic [2*DIM_W-1:0] total_prod;

	sog_pkg::dir_t     dir_adv;
	logic [CRD_W-1:0]  row_adv;
	logic [CRD_W-1:0]  col_adv;
	logic [CRD_W-1:0]  top_adv;
	logic [CRD_W-1:0]  bottom_adv;
	logic [CRD_W-1:0]  left_adv;
	logic [CRD_W-1:0]  right_adv;
	logic [LIN_FW-1:0] lin_adv;
	logic [CNT_W-1:0]  cnt_adv;

	logic              accept;
	logic              start;

	logic [CRD_XW-1:0] row_x;
	logic [CRD_XW-1:0] col_x;
	logic [LIN_XW-1:0] lin_x;
	logic [CNT_XW-1:0] cnt_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= sog_pkg::NUM_ROWS_RST;
			num_cols_q <= sog_pkg::NUM_COLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sog_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data;
				sog_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data;
				default: begin
					num_rows_q <= num_rows_q;
				end
			endcase
		end
	end

	// clamp dimensions to 1..MAX_DIM
	assign rows_x = CMP_W'(num_rows_q);
	assign cols_x = CMP_W'(num_cols_q);

	always_comb begin
		if (rows_x == '0) begin
			rows_cl = DIM_W'(1);
		end else if (rows_x > CMP_W'(MAX_DIM)) begin
			rows_cl = DIM_W'(MAX_DIM);
		end else begin
			rows_cl = rows_x[DIM_W-1:0];
		end
		if (cols_x == '0) begin
			cols_cl = DIM_W'(1);
		end else if (cols_x > CMP_W'(MAX_DIM)) begin
			cols_cl = DIM_W'(MAX_DIM);
		end else begin
			cols_cl = cols_x[DIM_W-1:0];
		end
	end

	assign total_prod = rows_cl * cols_cl;

	sog_step #(
		.CRD_W (CRD_W),
		.DIM_W (DIM_W),
		.LIN_FW(LIN_FW)
	) u_step (
		.lat_cols    (lat_cols_q),
		.dir         (dir_q),
		.cur_row     (row_q),
		.cur_col     (col_q),
		.top_bound   (top_q),
		.bottom_bound(bottom_q),
		.left_bound  (left_q),
		.right_bound (right_q),
		.lin         (lin_q),
		.dir_nx      (dir_adv),
		.row_nx      (row_adv),
		.col_nx      (col_adv),
		.top_nx      (top_adv),
		.bottom_nx   (bottom_adv),
		.left_nx     (left_adv),
		.right_nx    (right_adv),
		.lin_nx      (lin_adv)
	);

	assign cnt_adv  = cnt_q + 1'b1;
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign start    = restart || (cnt_q == '0) || (cnt_q >= total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_cols_q <= DIM_W'(sog_pkg::NUM_COLS_RST);
			total_q    <= CNT_W'(sog_pkg::NUM_ROWS_RST * sog_pkg::NUM_COLS_RST);
			cnt_q      <= '0;
			dir_q      <= sog_pkg::DIR_RIGHT;
			row_q      <= '0;
			col_q      <= '0;
			top_q      <= '0;
			left_q     <= '0;
			bottom_q   <= CRD_W'(sog_pkg::NUM_ROWS_RST - 1);
			right_q    <= CRD_W'(sog_pkg::NUM_COLS_RST - 1);
			lin_q      <= '0;
			last_q     <= 1'b0;
		end else if (accept) begin
			if (start) begin
				lat_cols_q <= cols_cl;
				total_q    <= total_prod[CNT_W-1:0];
				cnt_q      <= CNT_W'(1);
				dir_q      <= sog_pkg::DIR_RIGHT;
				row_q      <= '0;
				col_q      <= '0;
				top_q      <= '0;
				left_q     <= '0;
				bottom_q   <= CRD_W'(rows_cl - 1'b1);
				right_q    <= CRD_W'(cols_cl - 1'b1);
				lin_q      <= '0;
				last_q     <= (rows_cl == DIM_W'(1)) && (cols_cl == DIM_W'(1));
			end else begin
				cnt_q    <= cnt_adv;
				dir_q    <= dir_adv;
				row_q    <= row_adv;
				col_q    <= col_adv;
				top_q    <= top_adv;
				left_q   <= left_adv;
				bottom_q <= bottom_adv;
				right_q  <= right_adv;
				lin_q    <= lin_adv;
				last_q   <= (cnt_adv >= total_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// walk state doubles as the output register
	assign row_x = CRD_XW'(row_q);
	assign col_x = CRD_XW'(col_q);
	assign lin_x = LIN_XW'(lin_q);
	assign cnt_x = CNT_XW'(cnt_q);

	assign out_valid      = out_valid_q;
	assign row            = row_x[sog_pkg::ROW_W-1:0];
	assign col            = col_x[sog_pkg::COL_W-1:0];
	assign linear_index   = lin_x[sog_pkg::LIN_W-1:0];
	assign sequence_value = cnt_x[sog_pkg::SEQ_W-1:0];
	assign last           = last_q;

endmodule

`default_nettype wire
